/* rtl/owbg_pkg.sv */
// Shared widths, codes, types and reset values of the white-balance gain unit.
package owbg_pkg;

   localparam int BYTE_W      = 8;
   localparam int RATIO_W     = 10;
   localparam int GAIN_W      = 30;
   localparam int NUM_W       = RATIO_W + GAIN_W;
   localparam int DIV_STEPS   = NUM_W / 2;
   localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
   localparam int UNITY_SHIFT = 10;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FLAG_INVALID_BIT = 7;

   localparam logic [GAIN_W-1:0]  UNITY_GAIN     = 30'h400;
   localparam logic [RATIO_W-1:0] RED_TYP_RESET  = 10'd353;
   localparam logic [RATIO_W-1:0] BLUE_TYP_RESET = 10'd340;

   typedef enum logic {
      REG_RED_TYP  = 1'b0,
      REG_BLUE_TYP = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_GROUP   = 2'd1,
      STATUS_ZERO_RATIO = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_GR_GO,
      ST_GR_WAIT,
      ST_GB_GO,
      ST_GB_WAIT,
      ST_PICK,
      ST_MUL,
      ST_FIN_GO,
      ST_FIN_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   num;
      logic [RATIO_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [GAIN_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* rtl/owbg_divider.sv */
// Radix-4 restoring divider, two quotient bits per cycle, saturating quotient.
module owbg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  owbg_pkg::div_req_type div_req,
   output owbg_pkg::div_rsp_type div_rsp
);

   logic [owbg_pkg::NUM_W-1:0]      quo_ff, quo_in;
   logic [owbg_pkg::RATIO_W-1:0]    rem_ff, rem_in;
   logic [owbg_pkg::RATIO_W-1:0]    den_ff, den_in;
   logic [owbg_pkg::STEP_CNT_W-1:0] count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [owbg_pkg::RATIO_W:0] den_ext;
   logic [owbg_pkg::RATIO_W:0] trial1, trial2, diff1, diff2;
   logic                       ge1, ge2;
   logic [owbg_pkg::RATIO_W-1:0] rem1, rem2;

   // two dependent compare-subtract steps
   always_comb begin
      den_ext = {1'b0, den_ff};
      trial1  = {rem_ff, quo_ff[owbg_pkg::NUM_W-1]};
      diff1   = trial1 - den_ext;
      ge1     = (trial1 >= den_ext);
      rem1    = ge1 ? diff1[owbg_pkg::RATIO_W-1:0] : trial1[owbg_pkg::RATIO_W-1:0];
      trial2  = {rem1, quo_ff[owbg_pkg::NUM_W-2]};
      diff2   = trial2 - den_ext;
      ge2     = (trial2 >= den_ext);
      rem2    = ge2 ? diff2[owbg_pkg::RATIO_W-1:0] : trial2[owbg_pkg::RATIO_W-1:0];
   end

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         quo_in   = div_req.num;
         rem_in   = '0;
         den_in   = div_req.den;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[owbg_pkg::NUM_W-3:0], ge1, ge2};
         rem_in   = rem2;
         count_in = count_ff + 1'b1;
         if (count_ff == owbg_pkg::STEP_CNT_W'(owbg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // clamp anything past 30 bits (this also covers a zero divisor)
   always_comb begin
      div_rsp.done = done_ff;
      if (|quo_ff[owbg_pkg::NUM_W-1:owbg_pkg::GAIN_W]) begin
         div_rsp.quotient = '1;
      end else begin
         div_rsp.quotient = quo_ff[owbg_pkg::GAIN_W-1:0];
      end
   end

endmodule

/* rtl/otp_white_balance_gain_unit.sv */
// Top level of the white-balance gain unit: group selection, sequencer, registers.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-----------------------------------
//   req      | in        | req_valid / req_ready | flag, ratio high bytes, low bits, last
//   rsp      | out       | rsp_valid / rsp_ready | status, three gains, three write flags
//   csr      | in/out    | psel, penable, pready | typical red / blue ratio registers
//
// A group that is not the last leaves the block ready for the next one. After its acceptance
// a last group holds the input off for the run: no division when no usable group was kept
// or a kept ratio is zero, two when both kept ratios fall below the typical ones, two and a
// multiply when one does, and three and a multiply when neither does; each division is a
// launch, 20 two-bit steps and done in the shared divider, which sets the rate.
// Reset is synchronous and returns the typical ratios to 353 and 340.
// A stalled result sits in the output register; the next run may start meanwhile and
// only its own result waits for the slot to drain.
module otp_white_balance_gain_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_flag_byte,
   input  logic [7:0]  req_red_ratio_high,
   input  logic [7:0]  req_blue_ratio_high,
   input  logic [7:0]  req_low_bits_byte,
   input  logic        req_last_group,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [29:0] rsp_red_gain,
   output logic [29:0] rsp_green_gain,
   output logic [29:0] rsp_blue_gain,
   output logic        rsp_red_write,
   output logic        rsp_green_write,
   output logic        rsp_blue_write,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int RW = owbg_pkg::RATIO_W;
   localparam int GW = owbg_pkg::GAIN_W;
   localparam int NW = owbg_pkg::NUM_W;

   // sequencer
   owbg_pkg::state_type  state_ff, state_in;

   // configuration
   logic [RW-1:0] red_typ_ff, red_typ_in;
   logic [RW-1:0] blue_typ_ff, blue_typ_in;

   // kept group
   logic          found_ff, found_in;
   logic [RW-1:0] kept_r_ff, kept_r_in;
   logic [RW-1:0] kept_b_ff, kept_b_in;

   // run state
   owbg_pkg::status_type status_ff, status_in;
   logic          b_lt_ff, b_lt_in;
   logic          r_lt_ff, r_lt_in;
   logic          pick_r_ff, pick_r_in;
   logic [GW-1:0] gr_ff, gr_in;
   logic [GW-1:0] gb_ff, gb_in;
   logic [GW-1:0] fin_ff, fin_in;
   logic [NW-1:0] prod_ff, prod_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   owbg_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [GW-1:0]        rsp_red_ff, rsp_red_in;
   logic [GW-1:0]        rsp_green_ff, rsp_green_in;
   logic [GW-1:0]        rsp_blue_ff, rsp_blue_in;
   logic                 rsp_rw_ff, rsp_rw_in;
   logic                 rsp_gw_ff, rsp_gw_in;
   logic                 rsp_bw_ff, rsp_bw_in;

   // combinational helpers
   logic                    req_fire;
   logic                    cfg_write;
   owbg_pkg::reg_index_type cfg_sel;
   logic                    group_ok;
   logic [RW-1:0]           new_r, new_b;
   owbg_pkg::status_type    eval_status;
   logic                    eval_b_lt, eval_r_lt;
   logic                    rsp_load;
   logic [GW-1:0]           mul_a;
   logic [RW-1:0]           mul_b;
   logic [GW-1:0]           red_sel, green_sel, blue_sel;

   owbg_pkg::div_req_type div_req;
   owbg_pkg::div_rsp_type div_rsp;

   owbg_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // decode the incoming group and the register port
   always_comb begin
      req_fire  = req_valid && req_ready;
      cfg_write = psel && penable && pwrite && pready;
      cfg_sel   = owbg_pkg::reg_index_type'(paddr[2]);
      group_ok  = !req_flag_byte[owbg_pkg::FLAG_INVALID_BIT]
                  && ((|req_red_ratio_high) || (|req_blue_ratio_high));
      new_r     = {req_red_ratio_high, req_low_bits_byte[7:6]};
      new_b     = {req_blue_ratio_high, req_low_bits_byte[5:4]};
   end

   // classify the kept group against the typical ratios
   always_comb begin
      if (!found_ff) begin
         eval_status = owbg_pkg::STATUS_NO_GROUP;
      end else if (kept_r_ff == '0 || kept_b_ff == '0) begin
         eval_status = owbg_pkg::STATUS_ZERO_RATIO;
      end else begin
         eval_status = owbg_pkg::STATUS_OK;
      end
      eval_b_lt = (kept_b_ff < blue_typ_ff);
      eval_r_lt = (kept_r_ff < red_typ_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         owbg_pkg::ST_IDLE: begin
            if (req_fire && req_last_group) state_in = owbg_pkg::ST_EVAL;
         end
         owbg_pkg::ST_EVAL: begin
            if (eval_status != owbg_pkg::STATUS_OK) begin
               state_in = owbg_pkg::ST_OUT;
            end else if (!eval_b_lt && eval_r_lt) begin
               state_in = owbg_pkg::ST_GB_GO;   // only green from blue is needed
            end else begin
               state_in = owbg_pkg::ST_GR_GO;
            end
         end
         owbg_pkg::ST_GR_GO: state_in = owbg_pkg::ST_GR_WAIT;
         owbg_pkg::ST_GR_WAIT: begin
            if (div_rsp.done) begin
               state_in = (r_lt_ff || !b_lt_ff) ? owbg_pkg::ST_GB_GO : owbg_pkg::ST_PICK;
            end
         end
         owbg_pkg::ST_GB_GO: state_in = owbg_pkg::ST_GB_WAIT;
         owbg_pkg::ST_GB_WAIT: begin
            if (div_rsp.done) begin
               state_in = b_lt_ff ? owbg_pkg::ST_OUT : owbg_pkg::ST_PICK;
            end
         end
         owbg_pkg::ST_PICK:   state_in = owbg_pkg::ST_MUL;
         owbg_pkg::ST_MUL:    state_in = owbg_pkg::ST_FIN_GO;
         owbg_pkg::ST_FIN_GO: state_in = owbg_pkg::ST_FIN_WAIT;
         owbg_pkg::ST_FIN_WAIT: begin
            if (div_rsp.done) state_in = owbg_pkg::ST_OUT;
         end
         owbg_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = owbg_pkg::ST_IDLE;
         end
         default: state_in = owbg_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, divider launch and operand select
   always_comb begin
      req_ready     = (state_ff == owbg_pkg::ST_IDLE);
      rsp_load      = (state_ff == owbg_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);
      div_req.start = 1'b0;
      div_req.num   = prod_ff;
      div_req.den   = pick_r_ff ? kept_b_ff : kept_r_ff;
      case (state_ff)
         owbg_pkg::ST_GR_GO: begin
            div_req.start = 1'b1;
            if (r_lt_ff) begin
               // both ratios low: red gain straight from the typical ratio
               div_req.num = NW'({red_typ_ff, {owbg_pkg::UNITY_SHIFT{1'b0}}});
               div_req.den = kept_r_ff;
            end else begin
               div_req.num = NW'({kept_r_ff, {owbg_pkg::UNITY_SHIFT{1'b0}}});
               div_req.den = red_typ_ff;
            end
         end
         owbg_pkg::ST_GB_GO: begin
            div_req.start = 1'b1;
            if (b_lt_ff) begin
               div_req.num = NW'({blue_typ_ff, {owbg_pkg::UNITY_SHIFT{1'b0}}});
               div_req.den = kept_b_ff;
            end else begin
               div_req.num = NW'({kept_b_ff, {owbg_pkg::UNITY_SHIFT{1'b0}}});
               div_req.den = blue_typ_ff;
            end
         end
         owbg_pkg::ST_FIN_GO: begin
            div_req.start = 1'b1;
         end
         default: begin
            div_req.start = 1'b0;
         end
      endcase
   end

   // multiplier operands: green gain times the opposite typical ratio
   always_comb begin
      mul_a = pick_r_ff ? gr_ff : gb_ff;
      mul_b = pick_r_ff ? blue_typ_ff : red_typ_ff;
   end

   // assemble the three gains from the run's quotients
   always_comb begin
      if (b_lt_ff && r_lt_ff) begin
         red_sel   = gr_ff;
         green_sel = owbg_pkg::UNITY_GAIN;
         blue_sel  = gb_ff;
      end else if (pick_r_ff) begin
         red_sel   = owbg_pkg::UNITY_GAIN;
         green_sel = gr_ff;
         blue_sel  = fin_ff;
      end else begin
         red_sel   = fin_ff;
         green_sel = gb_ff;
         blue_sel  = owbg_pkg::UNITY_GAIN;
      end
   end

   // datapath next values
   always_comb begin
      red_typ_in    = red_typ_ff;
      blue_typ_in   = blue_typ_ff;
      found_in      = found_ff;
      kept_r_in     = kept_r_ff;
      kept_b_in     = kept_b_ff;
      status_in     = status_ff;
      b_lt_in       = b_lt_ff;
      r_lt_in       = r_lt_ff;
      pick_r_in     = pick_r_ff;
      gr_in         = gr_ff;
      gb_in         = gb_ff;
      fin_in        = fin_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_rw_in     = rsp_rw_ff;
      rsp_gw_in     = rsp_gw_ff;
      rsp_bw_in     = rsp_bw_ff;

      if (cfg_write) begin
         case (cfg_sel)
            owbg_pkg::REG_RED_TYP:  red_typ_in  = pwdata[RW-1:0];
            owbg_pkg::REG_BLUE_TYP: blue_typ_in = pwdata[RW-1:0];
            default:                red_typ_in  = red_typ_ff;
         endcase
      end

      // latch the first qualifying group, ignore the rest of the run
      if (req_fire && !found_ff && group_ok) begin
         found_in  = 1'b1;
         kept_r_in = new_r;
         kept_b_in = new_b;
      end

      case (state_ff)
         owbg_pkg::ST_EVAL: begin
            status_in = eval_status;
            b_lt_in   = eval_b_lt;
            r_lt_in   = eval_r_lt;
         end
         owbg_pkg::ST_GR_WAIT: begin
            if (div_rsp.done) gr_in = div_rsp.quotient;
         end
         owbg_pkg::ST_GB_WAIT: begin
            if (div_rsp.done) gb_in = div_rsp.quotient;
         end
         owbg_pkg::ST_PICK: begin
            // green comes from red unless only blue ran, or blue gave the larger green
            if (b_lt_ff) begin
               pick_r_in = 1'b1;
            end else if (r_lt_ff) begin
               pick_r_in = 1'b0;
            end else begin
               pick_r_in = !(gb_ff > gr_ff);
            end
         end
         owbg_pkg::ST_MUL: begin
            prod_in = NW'(mul_a) * NW'(mul_b);
         end
         owbg_pkg::ST_FIN_WAIT: begin
            if (div_rsp.done) fin_in = div_rsp.quotient;
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase

      // drain the result slot, then refill it at the end of a run
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         if (status_ff == owbg_pkg::STATUS_OK) begin
            rsp_red_in   = red_sel;
            rsp_green_in = green_sel;
            rsp_blue_in  = blue_sel;
            rsp_rw_in    = (red_sel > owbg_pkg::UNITY_GAIN);
            rsp_gw_in    = (green_sel > owbg_pkg::UNITY_GAIN);
            rsp_bw_in    = (blue_sel > owbg_pkg::UNITY_GAIN);
         end else begin
            rsp_red_in   = '0;
            rsp_green_in = '0;
            rsp_blue_in  = '0;
            rsp_rw_in    = 1'b0;
            rsp_gw_in    = 1'b0;
            rsp_bw_in    = 1'b0;
         end
         // start the next calibration run clean
         found_in  = 1'b0;
         kept_r_in = '0;
         kept_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= owbg_pkg::ST_IDLE;
         red_typ_ff   <= owbg_pkg::RED_TYP_RESET;
         blue_typ_ff  <= owbg_pkg::BLUE_TYP_RESET;
         found_ff     <= 1'b0;
         kept_r_ff    <= '0;
         kept_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_typ_ff   <= red_typ_in;
         blue_typ_ff  <= blue_typ_in;
         found_ff     <= found_in;
         kept_r_ff    <= kept_r_in;
         kept_b_ff    <= kept_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      b_lt_ff       <= b_lt_in;
      r_lt_ff       <= r_lt_in;
      pick_r_ff     <= pick_r_in;
      gr_ff         <= gr_in;
      gb_ff         <= gb_in;
      fin_ff        <= fin_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_rw_ff     <= rsp_rw_in;
      rsp_gw_ff     <= rsp_gw_in;
      rsp_bw_ff     <= rsp_bw_in;
   end

   // register read-back
   always_comb begin
      pready = 1'b1;
      case (cfg_sel)
         owbg_pkg::REG_RED_TYP:  prdata = owbg_pkg::CSR_DATA_W'(red_typ_ff);
         owbg_pkg::REG_BLUE_TYP: prdata = owbg_pkg::CSR_DATA_W'(blue_typ_ff);
         default:                prdata = '0;
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_red_gain    = rsp_red_ff;
   assign rsp_green_gain  = rsp_green_ff;
   assign rsp_blue_gain   = rsp_blue_ff;
   assign rsp_red_write   = rsp_rw_ff;
   assign rsp_green_write = rsp_gw_ff;
   assign rsp_blue_write  = rsp_bw_ff;

   // a last group holds off further requests while the run is computed
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_group) |=> !req_ready)
      else $error("request taken right after a last group");

   // a failed run reports no gains and no writes
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != owbg_pkg::STATUS_OK) |->
      (rsp_red_gain == '0 && rsp_green_gain == '0 && rsp_blue_gain == '0
       && !rsp_red_write && !rsp_green_write && !rsp_blue_write))
      else $error("failed run carries gains");

   // a good run has one channel pinned at unity
   a_unity_anchor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == owbg_pkg::STATUS_OK) |->
      (rsp_red_gain == owbg_pkg::UNITY_GAIN || rsp_green_gain == owbg_pkg::UNITY_GAIN
       || rsp_blue_gain == owbg_pkg::UNITY_GAIN))
      else $error("no gain at unity");

   // write flags follow the gains
   a_write_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == owbg_pkg::STATUS_OK) |->
      (rsp_red_write == (rsp_red_gain > owbg_pkg::UNITY_GAIN)
       && rsp_green_write == (rsp_green_gain > owbg_pkg::UNITY_GAIN)
       && rsp_blue_write == (rsp_blue_gain > owbg_pkg::UNITY_GAIN)))
      else $error("write flag mismatch");

endmodule

/* tb/sv/otp_white_balance_gain_unit_tb.sv */
// Self-checking testbench of the white-balance gain unit: stimulus, gain predictor, checks.
`timescale 1ns / 100ps

module otp_white_balance_gain_unit_tb;

   localparam int          HALF_PERIOD  = 2;
   localparam int          RESET_CYCLES = 4;
   localparam int          DRAIN_CYCLES = 100;   // longer than the longest last group
   localparam int          IDLE_LIMIT   = 4000;  // covers the long hold-off plus slack
   localparam int          HOLD_CYCLES  = 600;
   localparam int          HOLD_AT      = 400;   // requests accepted before the hold-off
   localparam int          MAX_REPORTS  = 10;
   localparam logic [29:0] GAIN_SAT     = 30'h3FFF_FFFF;

   // One stored calibration group as it enters the block.
   typedef struct {
      logic [7:0] flag_byte;
      logic [7:0] red_high;
      logic [7:0] blue_high;
      logic [7:0] low_bits;
      logic       last;
   } group_type;

   // One set of gains as it leaves the block.
   typedef struct {
      owbg_pkg::status_type status;
      logic [29:0]          red_gain;
      logic [29:0]          green_gain;
      logic [29:0]          blue_gain;
      logic                 red_write;
      logic                 green_write;
      logic                 blue_write;
   } gains_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_flag_byte = '0;
   logic [7:0]  req_red_ratio_high = '0;
   logic [7:0]  req_blue_ratio_high = '0;
   logic [7:0]  req_low_bits_byte = '0;
   logic        req_last_group = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [29:0] rsp_red_gain;
   logic [29:0] rsp_green_gain;
   logic [29:0] rsp_blue_gain;
   logic        rsp_red_write;
   logic        rsp_green_write;
   logic        rsp_blue_write;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Groups waiting to be offered, and gains waiting to come back.
   group_type   pending_groups[$];
   gains_type   gains_expected[$];

   // Predictor copy of the registers and of the kept group.
   logic [9:0]  red_typ = owbg_pkg::RED_TYP_RESET;
   logic [9:0]  blue_typ = owbg_pkg::BLUE_TYP_RESET;
   logic        found_group = 1'b0;
   logic [9:0]  red_kept = '0;
   logic [9:0]  blue_kept = '0;

   logic        req_taken = 1'b0;
   logic        quiet = 1'b0;       // no idling on either side when set
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;
   int unsigned groups_accepted = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;

   otp_white_balance_gain_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_flag_byte       (req_flag_byte),
      .req_red_ratio_high  (req_red_ratio_high),
      .req_blue_ratio_high (req_blue_ratio_high),
      .req_low_bits_byte   (req_low_bits_byte),
      .req_last_group      (req_last_group),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_red_gain        (rsp_red_gain),
      .rsp_green_gain      (rsp_green_gain),
      .rsp_blue_gain       (rsp_blue_gain),
      .rsp_red_write       (rsp_red_write),
      .rsp_green_write     (rsp_green_write),
      .rsp_blue_write      (rsp_blue_write),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Truncating division; a zero divisor and any overflow give the all-ones gain.
   function automatic logic [29:0] sat_div(input logic [63:0] num, input logic [9:0] den);
      logic [63:0] quo;
      if (den == '0) begin
         return GAIN_SAT;
      end
      quo = num / den;
      return (quo > GAIN_SAT) ? GAIN_SAT : quo[29:0];
   endfunction

   // Latch the first qualifying group; on the last group form the gains and clear the run.
   function automatic bit predict_gains(input group_type grp, output gains_type res);
      logic [29:0] gain_b;
      logic [29:0] gain_r;
      res = '{owbg_pkg::STATUS_OK, '0, '0, '0, 1'b0, 1'b0, 1'b0};
      if (!found_group && !grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] &&
          (grp.red_high != '0 || grp.blue_high != '0)) begin
         red_kept    = {grp.red_high, grp.low_bits[7:6]};
         blue_kept   = {grp.blue_high, grp.low_bits[5:4]};
         found_group = 1'b1;
      end
      if (!grp.last) begin
         return 1'b0;
      end
      if (!found_group) begin
         res.status = owbg_pkg::STATUS_NO_GROUP;
      end else if (red_kept == '0 || blue_kept == '0) begin
         res.status = owbg_pkg::STATUS_ZERO_RATIO;
      end else if (blue_kept < blue_typ && red_kept < red_typ) begin
         res.green_gain = owbg_pkg::UNITY_GAIN;
         res.blue_gain  = sat_div(64'(owbg_pkg::UNITY_GAIN) * blue_typ, blue_kept);
         res.red_gain   = sat_div(64'(owbg_pkg::UNITY_GAIN) * red_typ, red_kept);
      end else if (blue_kept < blue_typ) begin
         res.red_gain   = owbg_pkg::UNITY_GAIN;
         res.green_gain = sat_div(64'(owbg_pkg::UNITY_GAIN) * red_kept, red_typ);
         res.blue_gain  = sat_div(64'(res.green_gain) * blue_typ, blue_kept);
      end else if (red_kept < red_typ) begin
         res.blue_gain  = owbg_pkg::UNITY_GAIN;
         res.green_gain = sat_div(64'(owbg_pkg::UNITY_GAIN) * blue_kept, blue_typ);
         res.red_gain   = sat_div(64'(res.green_gain) * red_typ, red_kept);
      end else begin
         // Both kept ratios at or above typical: the larger green gain wins.
         gain_b = sat_div(64'(owbg_pkg::UNITY_GAIN) * blue_kept, blue_typ);
         gain_r = sat_div(64'(owbg_pkg::UNITY_GAIN) * red_kept, red_typ);
         if (gain_b > gain_r) begin
            res.blue_gain  = owbg_pkg::UNITY_GAIN;
            res.green_gain = gain_b;
            res.red_gain   = sat_div(64'(gain_b) * red_typ, red_kept);
         end else begin
            res.red_gain   = owbg_pkg::UNITY_GAIN;
            res.green_gain = gain_r;
            res.blue_gain  = sat_div(64'(gain_r) * blue_typ, blue_kept);
         end
      end
      if (res.status == owbg_pkg::STATUS_OK) begin
         res.red_write   = res.red_gain > owbg_pkg::UNITY_GAIN;
         res.green_write = res.green_gain > owbg_pkg::UNITY_GAIN;
         res.blue_write  = res.blue_gain > owbg_pkg::UNITY_GAIN;
      end
      found_group = 1'b0;
      red_kept    = '0;
      blue_kept   = '0;
      return 1'b1;
   endfunction

   // Request driver: change inputs at the falling edge, hold each request until taken.
   always @(negedge clock) begin
      group_type grp;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_groups.size() > 0) begin
            grp = pending_groups.pop_front();
            req_flag_byte       <= grp.flag_byte;
            req_red_ratio_high  <= grp.red_high;
            req_blue_ratio_high <= grp.blue_high;
            req_low_bits_byte   <= grp.low_bits;
            req_last_group      <= grp.last;
            req_valid           <= 1'b1;
            // Insert an idle burst after this request now and then.
            if (!quiet && $urandom_range(0, 5) == 0) begin
               send_gap <= $urandom_range(1, 19);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && groups_accepted >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted request, check each accepted result.
   always @(posedge clock) begin
      group_type grp;
      gains_type res;
      gains_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            grp = '{req_flag_byte, req_red_ratio_high, req_blue_ratio_high,
                    req_low_bits_byte, req_last_group};
            if (predict_gains(grp, res)) begin
               gains_expected.push_back(res);
            end
            groups_accepted <= groups_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (gains_expected.size() == 0) begin
               if (error_count < MAX_REPORTS) begin
                  $display("%0t: unexpected result status=%0d gains r=%0d g=%0d b=%0d",
                           $realtime, rsp_status, rsp_red_gain, rsp_green_gain,
                           rsp_blue_gain);
               end
               error_count <= error_count + 1;
            end else begin
               want = gains_expected.pop_front();
               if (rsp_status !== want.status || rsp_red_gain !== want.red_gain ||
                   rsp_green_gain !== want.green_gain || rsp_blue_gain !== want.blue_gain ||
                   rsp_red_write !== want.red_write || rsp_green_write !== want.green_write ||
                   rsp_blue_write !== want.blue_write) begin
                  if (error_count < MAX_REPORTS) begin
                     $display("%0t: mismatch expected st=%0d r=%0d g=%0d b=%0d wr=%b%b%b",
                              $realtime, want.status, want.red_gain, want.green_gain,
                              want.blue_gain, want.red_write, want.green_write,
                              want.blue_write);
                     $display("%0t:            actual st=%0d r=%0d g=%0d b=%0d wr=%b%b%b",
                              $realtime, rsp_status, rsp_red_gain, rsp_green_gain,
                              rsp_blue_gain, rsp_red_write, rsp_green_write,
                              rsp_blue_write);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Queue one group.
   task automatic add_group(input logic [7:0] flag_byte, input logic [7:0] red_high,
                            input logic [7:0] blue_high, input logic [7:0] low_bits,
                            input logic last);
      pending_groups.push_back(group_type'{flag_byte, red_high, blue_high, low_bits, last});
   endtask

   // Mostly candidate groups with random content; some invalid, blank or zero-ratio ones.
   function automatic group_type random_group(input logic last);
      group_type   grp;
      int unsigned pick;
      grp.flag_byte = 8'($urandom_range(0, 255));
      grp.red_high  = 8'($urandom_range(0, 255));
      grp.blue_high = 8'($urandom_range(0, 255));
      grp.low_bits  = 8'($urandom_range(0, 255));
      grp.last      = last;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] = 1'b0;
         // Land some ratios exactly on typical to hit the boundary branches.
         if ($urandom_range(0, 5) == 0) begin
            {grp.red_high, grp.low_bits[7:6]} = red_typ;
         end
         if ($urandom_range(0, 5) == 0) begin
            {grp.blue_high, grp.low_bits[5:4]} = blue_typ;
         end
      end else if (pick < 78) begin
         grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] = 1'b1;
      end else if (pick < 86) begin
         grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] = 1'b0;
         grp.red_high  = '0;
         grp.blue_high = '0;
      end else if (pick < 91) begin
         grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] = 1'b0;
         grp.red_high      = '0;
         grp.low_bits[7:6] = '0;
      end else if (pick < 96) begin
         grp.flag_byte[owbg_pkg::FLAG_INVALID_BIT] = 1'b0;
         grp.blue_high     = '0;
         grp.low_bits[5:4] = '0;
      end
      return grp;
   endfunction

   // Queue whole calibration runs of one to five groups until the count is reached.
   task automatic add_random_runs(input int unsigned n_groups);
      int unsigned count;
      int unsigned len;
      count = 0;
      while (count < n_groups) begin
         len = $urandom_range(1, 5);
         for (int k = 0; k < len; k++) begin
            pending_groups.push_back(random_group(k == len - 1));
         end
         count += len;
      end
   endtask

   // Wait until every request is taken and every result is back, then let the block settle.
   task automatic wait_idle();
      while (pending_groups.size() != 0 || req_valid || gains_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; the register takes the value at its end.
   task automatic csr_write(input owbg_pkg::reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == owbg_pkg::REG_RED_TYP) begin
         red_typ = value[owbg_pkg::RATIO_W-1:0];
      end else begin
         blue_typ = value[owbg_pkg::RATIO_W-1:0];
      end
   endtask

   // Write both typical ratios, with random bits above the register width.
   task automatic set_typicals(input logic [9:0] red_value, input logic [9:0] blue_value);
      csr_write(owbg_pkg::REG_RED_TYP, {22'($urandom_range(0, 4194303)), red_value});
      csr_write(owbg_pkg::REG_BLUE_TYP, {22'($urandom_range(0, 4194303)), blue_value});
   endtask

   initial begin
      logic [9:0] extremes[5][2];
      extremes = '{'{10'd1, 10'd1}, '{10'd1023, 10'd1023}, '{10'd0, 10'd0},
                   '{10'd1023, 10'd1}, '{10'd0, 10'd1023}};

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed runs at the reset typicals (red 353, blue 340).
      add_group(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // invalid flag only: no group
      add_group(8'h00, 8'h00, 8'h00, 8'hF0, 1'b1);  // both high bytes zero: no group
      add_group(8'h00, 8'h00, 8'h40, 8'hC0, 1'b1);  // red only in low bits; both below typical
      add_group(8'h80, 8'h12, 8'h34, 8'h00, 1'b0);  // invalid, skipped
      add_group(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);  // kept: both ratios at maximum
      add_group(8'h00, 8'h01, 8'h01, 8'h00, 1'b0);  // later group, ignored
      add_group(8'h7F, 8'h00, 8'h00, 8'h00, 1'b1);  // last group blank
      add_group(8'h00, 8'h00, 8'h10, 8'h00, 1'b1);  // zero red ratio
      add_group(8'h00, 8'h10, 8'h00, 8'hC0, 1'b1);  // zero blue ratio
      add_group(8'h00, 8'h00, 8'h01, 8'h40, 1'b1);  // both below typical
      add_group(8'h00, 8'hFF, 8'h01, 8'hC0, 1'b1);  // red above, blue below
      add_group(8'h00, 8'h58, 8'h55, 8'h40, 1'b1);  // exactly typical: equal green gains
      add_group(8'h00, 8'h58, 8'hFF, 8'h70, 1'b1);  // red at typical, blue high
      add_group(8'h7F, 8'hAA, 8'h55, 8'hAA, 1'b1);  // last group valid by itself
      wait_idle();

      // Extreme typicals, zero included, each with a short burst of random runs.
      foreach (extremes[i]) begin
         set_typicals(extremes[i][0], extremes[i][1]);
         add_random_runs(40);
         wait_idle();
      end

      // Random typicals; the final phase runs with no idling at all.
      for (int phase = 0; phase < 10; phase++) begin
         set_typicals(10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)));
         if (phase == 9) begin
            quiet = 1'b1;
         end
         add_random_runs(150);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
